/* src/r16_pkg.sv */
// ----------------------------------------------------------------------------
// r16_pkg
// shared constants, opcodes, status codes and state type of the risc16 step core
// ----------------------------------------------------------------------------
package r16_pkg;

    localparam int MEM_WORDS_DEF = 1024;
    localparam int NUM_REGS_DEF  = 8;
    localparam logic [31:0] CYCLE_LIMIT_RST = 32'd1000000;

    localparam logic [3:0] ST_OK        = 4'd0;
    localparam logic [3:0] ST_HALT      = 4'd1;
    localparam logic [3:0] ST_PC_OUT    = 4'd2;
    localparam logic [3:0] ST_LOAD_OUT  = 4'd3;
    localparam logic [3:0] ST_STORE_OUT = 4'd4;
    localparam logic [3:0] ST_JUMP_BAD  = 4'd5;
    localparam logic [3:0] ST_CYCLE     = 4'd6;
    localparam logic [3:0] ST_BAD_OP    = 4'd7;
    localparam logic [3:0] ST_BAD_SVC   = 4'd8;
    localparam logic [3:0] ST_IDLE      = 4'd9;

    localparam logic [5:0] OP_ADD   = 6'd0;
    localparam logic [5:0] OP_SUB   = 6'd1;
    localparam logic [5:0] OP_MUL   = 6'd2;
    localparam logic [5:0] OP_DIV   = 6'd3;
    localparam logic [5:0] OP_EQ    = 6'd4;
    localparam logic [5:0] OP_NE    = 6'd5;
    localparam logic [5:0] OP_LOAD  = 6'd15;
    localparam logic [5:0] OP_STORE = 6'd16;
    localparam logic [5:0] OP_SYS   = 6'd63;

    localparam logic [1:0] IOP_JMP = 2'd0;
    localparam logic [1:0] IOP_JNZ = 2'd1;
    localparam logic [1:0] IOP_MOV = 2'd3;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_FETCH,
        S_DECODE,
        S_RB,
        S_EXEC,
        S_DIV,
        S_MEMRD,
        S_MEMWAIT,
        S_FINISH
    } state_t;

endpackage

/* src/r16_div.sv */
// ----------------------------------------------------------------------------
// r16_div
// 16-bit unsigned restoring divider, one quotient bit per cycle
// ----------------------------------------------------------------------------
module r16_div
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    input  logic [15:0] dividend,
    input  logic [15:0] divisor,
    output logic        done,
    output logic [15:0] quotient
);

    logic [15:0] quo_reg;
    logic [15:0] rem_reg;
    logic [15:0] den_reg;
    logic [4:0]  cnt_reg;
    logic        busy_reg;
    logic [16:0] trial;

    assign trial    = {rem_reg, quo_reg[15]} - {1'b0, den_reg};
    assign quotient = quo_reg;
    assign done     = busy_reg && (cnt_reg == 5'd0);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= 5'd0;
        end
        else if (start)
        begin
            busy_reg <= 1'b1;
            cnt_reg  <= 5'd16;
        end
        else if (busy_reg)
        begin
            if (cnt_reg == 5'd0)
                busy_reg <= 1'b0;
            else
                cnt_reg <= cnt_reg - 5'd1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (start)
        begin
            quo_reg <= dividend;
            rem_reg <= 16'd0;
            den_reg <= divisor;
        end
        else if (busy_reg && cnt_reg != 5'd0)
        begin
            if (!trial[16])
            begin
                rem_reg <= trial[15:0];
                quo_reg <= {quo_reg[14:0], 1'b1};
            end
            else
            begin
                rem_reg <= {rem_reg[14:0], quo_reg[15]};
                quo_reg <= {quo_reg[14:0], 1'b0};
            end
        end
    end

endmodule

/* src/risc16_instruction_step.sv */
// ----------------------------------------------------------------------------
// risc16_instruction_step
// multicycle 16-bit core executing one instruction per step command
// ----------------------------------------------------------------------------
// usage:
//  - a command word is taken when start is high and busy is low; operation 0
//    writes load_data into the word memory, operation 1 runs one instruction
//  - every command gives exactly one result word, shown for one cycle with
//    done high; the receiver cannot stall, so nothing ever waits for it
//  - cycle_limit is to be written via cfg_valid/cfg_ready while idle; the block does not enforce it
//  - states to the result word: fetch alone for a load, an idle step or a
//    pc fault; else fetch, decode, register read, execute, finish, with the
//    divide state added for multiply and divide (waiting on the serial
//    divider unless by zero) and a memory read and wait for a load instruction
//  - one command at a time: busy stays high from acceptance to done
//  - after reset a clearing pass zeroes the word memory, during which busy
//    is high; configuration writes are taken meanwhile
//  - the register file is a small synchronous memory read three times per
//    step (r0, then both sources, one port read a cycle) and written back
//    at finish
// ----------------------------------------------------------------------------
module risc16_instruction_step
#(
    parameter int MEM_WORDS = r16_pkg::MEM_WORDS_DEF,
    parameter int NUM_REGS  = r16_pkg::NUM_REGS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  logic        operation,
    input  logic [9:0]  load_address,
    input  logic [15:0] load_data,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [31:0] cfg_data,
    output logic        done,
    output logic [10:0] program_counter,
    output logic        running,
    output logic [3:0]  status,
    output logic        reg_written,
    output logic [2:0]  dest_register,
    output logic [15:0] dest_value
);

    localparam int AW = (MEM_WORDS > 1) ? $clog2(MEM_WORDS) : 1;
    localparam int RW = $clog2(NUM_REGS);
    localparam logic [10:0] MEM_LIM = 11'(MEM_WORDS);

    // storage
    logic [15:0] mem [MEM_WORDS];
    logic [15:0] rf  [NUM_REGS];

    // the register file starts all zero: a valid bit per entry makes
    // unwritten entries read as zero
    logic [NUM_REGS-1:0] rvalid_reg;
    logic [RW-1:0]       rlast_reg;
    logic [15:0]         rf_q;

    r16_pkg::state_t state_reg, state_next;

    logic [31:0] limit_reg;
    logic [31:0] count_reg, count_next;
    logic [10:0] pc_reg, pc_next;
    logic        run_reg, run_next;
    logic [AW-1:0] clr_reg, clr_next;

    logic        op_reg;
    logic [9:0]  la_reg;
    logic [15:0] ld_reg;
    logic [15:0] ins_reg, ins_next;
    logic [15:0] v1_reg, v1_next;
    logic [15:0] v2_reg, v2_next;
    logic [15:0] r0_reg, r0_next;

    // result registers
    logic        done_reg;
    logic [3:0]  st_reg, st_next;
    logic        wr_reg, wr_next;
    logic [2:0]  rd_reg, rd_next;
    logic [15:0] val_reg, val_next;

    // memory port controls
    logic          mwe;
    logic [AW-1:0] maddr_w;
    logic [15:0]   mwdata;
    logic [AW-1:0] maddr_r;
    logic [15:0]   mrdata;

    logic          rwe;
    logic [RW-1:0] raddr_w;
    logic [15:0]   rwdata;
    logic [RW-1:0] raddr_r;
    logic [15:0]   rrdata;

    logic          fin;
    logic          div_start, div_done;
    logic [15:0]   div_q;
    logic [31:0]   prod;
    logic [31:0]   cnt_inc;

    r16_div u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (v1_reg),
        .divisor  (v2_reg),
        .done     (div_done),
        .quotient (div_q)
    );

    always_ff @(posedge clk)
    begin
        if (mwe)
            mem[maddr_w] <= mwdata;
        mrdata <= mem[maddr_r];
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
            rf[raddr_w] <= rwdata;
        rrdata <= rf[raddr_r];
    end

    assign prod      = v1_reg * v2_reg;
    assign cnt_inc   = (count_reg == 32'hFFFF_FFFF) ? count_reg : count_reg + 32'd1;
    assign busy      = (state_reg != r16_pkg::S_IDLE);
    assign cfg_ready = 1'b1;

    always_comb
    begin
        state_next = state_reg;
        count_next = count_reg;
        pc_next    = pc_reg;
        run_next   = run_reg;
        clr_next   = clr_reg;
        ins_next   = ins_reg;
        v1_next    = v1_reg;
        v2_next    = v2_reg;
        r0_next    = r0_reg;
        st_next    = st_reg;
        wr_next    = wr_reg;
        rd_next    = rd_reg;
        val_next   = val_reg;
        mwe        = 1'b0;
        maddr_w    = clr_reg;
        mwdata     = 16'd0;
        maddr_r    = pc_reg[AW-1:0];
        rwe        = 1'b0;
        raddr_w    = rd_reg;
        rwdata     = val_reg;
        raddr_r    = RW'(0);
        fin        = 1'b0;
        div_start  = 1'b0;

        unique case (state_reg)
            r16_pkg::S_CLEAR:
            begin
                mwe = 1'b1;
                if (clr_reg == AW'(MEM_WORDS - 1))
                    state_next = r16_pkg::S_IDLE;
                else
                    clr_next = clr_reg + AW'(1);
            end
            r16_pkg::S_IDLE:
            begin
                st_next  = r16_pkg::ST_OK;
                wr_next  = 1'b0;
                rd_next  = 3'd0;
                val_next = 16'd0;
                if (start)
                    state_next = r16_pkg::S_FETCH;
            end
            r16_pkg::S_FETCH:
            begin
                // load command, idle or pc check; otherwise read pc word and r0
                raddr_r = RW'(0);
                if (!op_reg)
                begin
                    if ({1'b0, la_reg} < MEM_LIM)
                    begin
                        mwe     = 1'b1;
                        maddr_w = la_reg[AW-1:0];
                        mwdata  = ld_reg;
                    end
                    if (!run_reg)
                        count_next = 32'd0;
                    run_next = 1'b1;
                    fin      = 1'b1;
                end
                else if (!run_reg)
                begin
                    st_next = r16_pkg::ST_IDLE;
                    fin     = 1'b1;
                end
                else if (pc_reg >= MEM_LIM)
                begin
                    run_next = 1'b0;
                    st_next  = r16_pkg::ST_PC_OUT;
                    fin      = 1'b1;
                end
                else
                begin
                    state_next = r16_pkg::S_DECODE;
                end
                if (fin)
                    state_next = r16_pkg::S_IDLE;
            end
            r16_pkg::S_DECODE:
            begin
                ins_next   = mrdata;
                r0_next    = rf_q;
                pc_next    = pc_reg + 11'd1;
                raddr_r    = mrdata[15] ? RW'(mrdata[12:10]) : RW'(mrdata[5:3]);
                state_next = r16_pkg::S_RB;
            end
            r16_pkg::S_RB:
            begin
                v1_next    = rf_q;
                raddr_r    = RW'(ins_reg[2:0]);
                state_next = r16_pkg::S_EXEC;
            end
            r16_pkg::S_EXEC:
            begin
                state_next = r16_pkg::S_FINISH;
                if (!ins_reg[15])
                begin
                    v2_next = rf_q;
                    rd_next = ins_reg[8:6];
                    wr_next = 1'b1;
                    unique case (ins_reg[14:9])
                        r16_pkg::OP_ADD: val_next = v1_reg + rf_q;
                        r16_pkg::OP_SUB: val_next = v1_reg - rf_q;
                        r16_pkg::OP_MUL, r16_pkg::OP_DIV:
                        begin
                            wr_next    = 1'b0;
                            state_next = r16_pkg::S_DIV;
                        end
                        r16_pkg::OP_EQ: val_next = {15'd0, v1_reg == rf_q};
                        r16_pkg::OP_NE: val_next = {15'd0, v1_reg != rf_q};
                        r16_pkg::OP_LOAD:
                        begin
                            wr_next = 1'b0;
                            rd_next = 3'd0;
                            if (v1_reg >= {5'd0, MEM_LIM})
                            begin
                                run_next = 1'b0;
                                st_next  = r16_pkg::ST_LOAD_OUT;
                            end
                            else
                            begin
                                rd_next    = ins_reg[8:6];
                                state_next = r16_pkg::S_MEMRD;
                            end
                        end
                        r16_pkg::OP_STORE:
                        begin
                            wr_next = 1'b0;
                            rd_next = 3'd0;
                            if (v1_reg >= {5'd0, MEM_LIM})
                            begin
                                run_next = 1'b0;
                                st_next  = r16_pkg::ST_STORE_OUT;
                            end
                            else
                            begin
                                mwe     = 1'b1;
                                maddr_w = v1_reg[AW-1:0];
                                mwdata  = rf_q;
                            end
                        end
                        r16_pkg::OP_SYS:
                        begin
                            wr_next = 1'b0;
                            rd_next = 3'd0;
                            if (r0_reg == 16'd0)
                            begin
                                run_next = 1'b0;
                                st_next  = r16_pkg::ST_HALT;
                            end
                            else
                                st_next = r16_pkg::ST_BAD_SVC;
                        end
                        default:
                        begin
                            wr_next = 1'b0;
                            rd_next = 3'd0;
                            st_next = r16_pkg::ST_BAD_OP;
                        end
                    endcase
                end
                else
                begin
                    unique case (ins_reg[14:13])
                        r16_pkg::IOP_JMP, r16_pkg::IOP_JNZ:
                        begin
                            if (ins_reg[13] == 1'b0 || v1_reg != 16'd0)
                            begin
                                if ({1'b0, ins_reg[9:0]} >= MEM_LIM)
                                begin
                                    run_next = 1'b0;
                                    st_next  = r16_pkg::ST_JUMP_BAD;
                                end
                                else
                                    pc_next = {1'b0, ins_reg[9:0]};
                            end
                        end
                        r16_pkg::IOP_MOV:
                        begin
                            wr_next  = 1'b1;
                            rd_next  = ins_reg[12:10];
                            val_next = {6'd0, ins_reg[9:0]};
                        end
                        default: st_next = r16_pkg::ST_BAD_OP;
                    endcase
                end
            end
            r16_pkg::S_DIV:
            begin
                // mul finishes here at once; div by zero gives zero, other divs run the serial divider
                if (ins_reg[14:9] == r16_pkg::OP_MUL)
                begin
                    wr_next    = 1'b1;
                    val_next   = prod[15:0];
                    state_next = r16_pkg::S_FINISH;
                end
                else if (v2_reg == 16'd0)
                begin
                    wr_next    = 1'b1;
                    val_next   = 16'd0;
                    state_next = r16_pkg::S_FINISH;
                end
                else if (div_done)
                begin
                    wr_next    = 1'b1;
                    val_next   = div_q;
                    state_next = r16_pkg::S_FINISH;
                end
                else if (!wr_reg && st_reg == r16_pkg::ST_OK && val_reg == 16'd0)
                begin
                    div_start = 1'b1;
                    val_next  = 16'd1;
                end
            end
            r16_pkg::S_MEMRD:
            begin
                maddr_r    = v1_reg[AW-1:0];
                state_next = r16_pkg::S_MEMWAIT;
            end
            r16_pkg::S_MEMWAIT:
            begin
                wr_next    = 1'b1;
                val_next   = mrdata;
                state_next = r16_pkg::S_FINISH;
            end
            r16_pkg::S_FINISH:
            begin
                // write back, count the instruction and check the limit
                rwe        = wr_reg;
                count_next = cnt_inc;
                if (cnt_inc > limit_reg && run_reg)
                begin
                    run_next = 1'b0;
                    st_next  = r16_pkg::ST_CYCLE;
                end
                fin        = 1'b1;
                state_next = r16_pkg::S_IDLE;
            end
            default: state_next = r16_pkg::S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= r16_pkg::S_CLEAR;
            limit_reg <= r16_pkg::CYCLE_LIMIT_RST;
            count_reg <= 32'd0;
            pc_reg    <= 11'd1;
            run_reg   <= 1'b0;
            clr_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            pc_reg    <= pc_next;
            run_reg   <= run_next;
            clr_reg   <= clr_next;
            done_reg  <= fin;
            if (cfg_valid)
                limit_reg <= cfg_data;
        end
    end

    // payload registers, no reset needed
    always_ff @(posedge clk)
    begin
        if (state_reg == r16_pkg::S_IDLE && start)
        begin
            op_reg <= operation;
            la_reg <= load_address;
            ld_reg <= load_data;
        end
        ins_reg <= ins_next;
        v1_reg  <= v1_next;
        v2_reg  <= v2_next;
        r0_reg  <= r0_next;
        st_reg  <= st_next;
        wr_reg  <= wr_next;
        rd_reg  <= rd_next;
        val_reg <= val_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rvalid_reg <= '0;
        else if (rwe)
            rvalid_reg[raddr_w] <= 1'b1;
    end

    always_ff @(posedge clk)
    begin
        rlast_reg <= raddr_r;
    end

    assign rf_q = rvalid_reg[rlast_reg] ? rrdata : 16'd0;

    assign done            = done_reg;
    assign program_counter = pc_reg;
    assign running         = run_reg;
    assign status          = st_reg;
    assign reg_written     = wr_reg;
    assign dest_register   = rd_reg;
    assign dest_value      = val_reg;

endmodule
